>>> rtl/core/osstb_pkg.sv
`timescale 1ns / 1ps

package osstb_pkg;

  localparam int unsigned NUM_TIMERS = 8;
  localparam int unsigned IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned CNT_W      = $clog2(NUM_TIMERS + 1);
  localparam int unsigned ID_W       = 4;
  localparam int unsigned OP_W       = 3;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned STEP_W     = 16;
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(100);

  typedef enum logic [OP_W-1:0] {
    OP_TICK     = 3'd0,
    OP_REGISTER = 3'd1,
    OP_START    = 3'd2,
    OP_STOP     = 3'd3,
    OP_RELOAD   = 3'd4,
    OP_READ     = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK_WB,
    ST_TICK_END,
    ST_REG_DIV,
    ST_START_WB,
    ST_READ_OUT
  } state_e;

  typedef struct packed {
    logic              timeout_we;
    logic [IDX_W-1:0]  timeout_waddr;
    logic [DATA_W-1:0] timeout_wdata;
    logic [IDX_W-1:0]  timeout_raddr;
    logic              count_we;
    logic [IDX_W-1:0]  count_waddr;
    logic [DATA_W-1:0] count_wdata;
    logic [IDX_W-1:0]  count_raddr;
  } mem_req_t;

endpackage

>>> rtl/core/one_shot_software_timer_bank.sv
`timescale 1ns / 1ps
// Results: stop, reload, refused ops and a tick with no timer allocated are registered from idle;
// start and read wait for one store read; a tick over the allocated timers does one count store
// read-modify-write a cycle, then gives a closing result; register waits for the bit-serial
// remainder unit (one bit a cycle). Throughput: busy falls with the last result, so the next
// transaction is taken at the edge that ends it. Each result is shown for one cycle; the
// receiver cannot stall. Reset clears the running flags and allocation count, tick_step is 100.
module one_shot_software_timer_bank (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [osstb_pkg::OP_W-1:0]   op_i,
  input  logic [osstb_pkg::ID_W-1:0]   timer_id_i,
  input  logic [osstb_pkg::DATA_W-1:0] timeout_i,
  input  logic                         cfg_we_i,
  input  logic [osstb_pkg::STEP_W-1:0] cfg_wdata_i,
  output logic                         result_valid_o,
  output logic                         ok_o,
  output logic [osstb_pkg::ID_W-1:0]   result_id_o,
  output logic [osstb_pkg::DATA_W-1:0] count_value_o,
  output logic                         expired_o,
  output logic                         last_o
);
  import osstb_pkg::*;

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q;
  logic [NUM_TIMERS-1:0] running_q, running_d;
  logic [CNT_W-1:0]  alloc_q, alloc_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [DATA_W-1:0] to_q;

  logic              res_valid_q, res_valid_d;
  logic              ok_q, ok_d;
  logic [ID_W-1:0]   res_id_q, res_id_d;
  logic [DATA_W-1:0] cnt_q, cnt_d;
  logic              exp_q, exp_d;
  logic              last_q, last_d;

  mem_req_t          mem_req;
  logic [DATA_W-1:0] timeout_rdata;
  logic [DATA_W-1:0] count_rdata;
  logic [DATA_W-1:0] tick_cnt;

  logic              accept;
  logic              id_ok;
  logic [IDX_W-1:0]  id_idx;
  logic              mod_start;
  logic              mod_done;
  logic [STEP_W-1:0] mod_rem;

  osstb_store u_store (
    .clk_i           (clk_i),
    .req_i           (mem_req),
    .timeout_rdata_o (timeout_rdata),
    .count_rdata_o   (count_rdata)
  );

  osstb_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (timeout_i),
    .divisor_i  (step_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  assign busy     = (state_q != ST_IDLE);
  assign accept   = start && !busy;
  assign id_ok    = (timer_id_i != '0) && (CNT_W'(timer_id_i) <= alloc_q);
  assign id_idx   = IDX_W'(timer_id_i - ID_W'(1));
  assign tick_cnt = count_rdata - DATA_W'(step_q);

  always_comb begin
    state_d     = state_q;
    running_d   = running_q;
    alloc_d     = alloc_q;
    idx_d       = idx_q;
    mod_start   = 1'b0;
    mem_req     = '0;
    res_valid_d = 1'b0;
    ok_d        = 1'b0;
    res_id_d    = '0;
    cnt_d       = '0;
    exp_d       = 1'b0;
    last_d      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (op_e'(op_i))
            OP_TICK: begin
              idx_d               = '0;
              mem_req.count_raddr = '0;
              if (alloc_q != '0) begin
                state_d = ST_TICK_WB;
              end else begin
                res_valid_d = 1'b1;
                ok_d        = 1'b1;
                last_d      = 1'b1;
              end
            end
            OP_REGISTER: begin
              if (alloc_q != CNT_W'(NUM_TIMERS) && step_q != '0 &&
                  timeout_i >= DATA_W'(step_q)) begin
                mod_start = 1'b1;
                state_d   = ST_REG_DIV;
              end else begin
                res_valid_d = 1'b1;
                last_d      = 1'b1;
              end
            end
            OP_START: begin
              mem_req.timeout_raddr = id_idx;
              idx_d                 = id_idx;
              if (id_ok) begin
                state_d = ST_START_WB;
              end else begin
                res_valid_d = 1'b1;
                last_d      = 1'b1;
              end
            end
            OP_STOP: begin
              res_valid_d = 1'b1;
              last_d      = 1'b1;
              if (id_ok) begin
                running_d[id_idx] = 1'b0;
                ok_d              = 1'b1;
              end
            end
            OP_RELOAD: begin
              res_valid_d = 1'b1;
              last_d      = 1'b1;
              if (id_ok) begin
                mem_req.timeout_we    = 1'b1;
                mem_req.timeout_waddr = id_idx;
                mem_req.timeout_wdata = timeout_i;
                mem_req.count_we      = running_q[id_idx];
                mem_req.count_waddr   = id_idx;
                mem_req.count_wdata   = timeout_i;
                ok_d                  = 1'b1;
              end
            end
            OP_READ: begin
              mem_req.count_raddr = id_idx;
              if (id_ok) begin
                state_d = ST_READ_OUT;
              end else begin
                res_valid_d = 1'b1;
                last_d      = 1'b1;
              end
            end
            default: begin
              res_valid_d = 1'b1;
              last_d      = 1'b1;
            end
          endcase
        end
      end

      ST_TICK_WB: begin
        if (running_q[idx_q]) begin
          mem_req.count_we    = 1'b1;
          mem_req.count_waddr = idx_q;
          mem_req.count_wdata = tick_cnt;
          if (tick_cnt == '0) begin
            running_d[idx_q] = 1'b0;
            res_valid_d      = 1'b1;
            ok_d             = 1'b1;
            res_id_d         = ID_W'(idx_q) + ID_W'(1);
            exp_d            = 1'b1;
          end
        end
        if (CNT_W'(idx_q) + CNT_W'(1) < alloc_q) begin
          idx_d               = idx_q + IDX_W'(1);
          mem_req.count_raddr = idx_q + IDX_W'(1);
        end else begin
          state_d = ST_TICK_END;
        end
      end

      ST_TICK_END: begin
        res_valid_d = 1'b1;
        ok_d        = 1'b1;
        last_d      = 1'b1;
        state_d     = ST_IDLE;
      end

      ST_REG_DIV: begin
        if (mod_done) begin
          res_valid_d = 1'b1;
          last_d      = 1'b1;
          state_d     = ST_IDLE;
          if (mod_rem == '0) begin
            mem_req.timeout_we    = 1'b1;
            mem_req.timeout_waddr = IDX_W'(alloc_q);
            mem_req.timeout_wdata = to_q;
            mem_req.count_we      = 1'b1;
            mem_req.count_waddr   = IDX_W'(alloc_q);
            mem_req.count_wdata   = '0;
            running_d[IDX_W'(alloc_q)] = 1'b0;
            alloc_d               = alloc_q + CNT_W'(1);
            ok_d                  = 1'b1;
            res_id_d              = ID_W'(alloc_q + CNT_W'(1));
          end
        end
      end

      ST_START_WB: begin
        mem_req.count_we    = 1'b1;
        mem_req.count_waddr = idx_q;
        mem_req.count_wdata = timeout_rdata;
        running_d[idx_q]    = 1'b1;
        res_valid_d         = 1'b1;
        ok_d                = 1'b1;
        last_d              = 1'b1;
        state_d             = ST_IDLE;
      end

      ST_READ_OUT: begin
        res_valid_d = 1'b1;
        ok_d        = 1'b1;
        cnt_d       = count_rdata;
        last_d      = 1'b1;
        state_d     = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= STEP_RESET;
      running_q   <= '0;
      alloc_q     <= '0;
      idx_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      running_q   <= running_d;
      alloc_q     <= alloc_d;
      idx_q       <= idx_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        step_q <= cfg_wdata_i;
      end
    end
  end

  // hold the timeout of the accepted transaction for the register write-back
  always_ff @(posedge clk_i) begin
    if (accept) begin
      to_q <= timeout_i;
    end
    ok_q     <= ok_d;
    res_id_q <= res_id_d;
    cnt_q    <= cnt_d;
    exp_q    <= exp_d;
    last_q   <= last_d;
  end

  assign result_valid_o = res_valid_q;
  assign ok_o           = ok_q;
  assign result_id_o    = res_id_q;
  assign count_value_o  = cnt_q;
  assign expired_o      = exp_q;
  assign last_o         = last_q;

endmodule

>>> rtl/core/osstb_store.sv
`timescale 1ns / 1ps

module osstb_store (
  input  logic                        clk_i,
  input  osstb_pkg::mem_req_t         req_i,
  output logic [osstb_pkg::DATA_W-1:0] timeout_rdata_o,
  output logic [osstb_pkg::DATA_W-1:0] count_rdata_o
);
  import osstb_pkg::*;

  logic [DATA_W-1:0] timeout_mem [NUM_TIMERS];
  logic [DATA_W-1:0] count_mem   [NUM_TIMERS];

  always_ff @(posedge clk_i) begin
    if (req_i.timeout_we) begin
      timeout_mem[req_i.timeout_waddr] <= req_i.timeout_wdata;
    end
    timeout_rdata_o <= timeout_mem[req_i.timeout_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (req_i.count_we) begin
      count_mem[req_i.count_waddr] <= req_i.count_wdata;
    end
    count_rdata_o <= count_mem[req_i.count_raddr];
  end

endmodule

>>> rtl/core/osstb_mod.sv
`timescale 1ns / 1ps

module osstb_mod (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [osstb_pkg::DATA_W-1:0] dividend_i,
  input  logic [osstb_pkg::STEP_W-1:0] divisor_i,
  output logic                         done_o,
  output logic [osstb_pkg::STEP_W-1:0] rem_o
);
  import osstb_pkg::*;

  localparam int unsigned STEPS_W = $clog2(DATA_W);

  logic               active_q, active_d;
  logic               done_q, done_d;
  logic [STEPS_W-1:0] step_q, step_d;
  logic [DATA_W-1:0]  quot_q, quot_d;
  logic [STEP_W-1:0]  div_q, div_d;
  logic [STEP_W-1:0]  rem_q, rem_d;
  logic [STEP_W:0]    trial;

  always_comb begin
    active_d = active_q;
    done_d   = 1'b0;
    step_d   = step_q;
    quot_d   = quot_q;
    div_d    = div_q;
    rem_d    = rem_q;
    trial    = {rem_q, quot_q[DATA_W-1]};
    if (start_i) begin
      active_d = 1'b1;
      step_d   = '0;
      quot_d   = dividend_i;
      div_d    = divisor_i;
      rem_d    = '0;
    end else if (active_q) begin
      quot_d = {quot_q[DATA_W-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        rem_d = STEP_W'(trial - {1'b0, div_q});
      end else begin
        rem_d = trial[STEP_W-1:0];
      end
      step_d = step_q + STEPS_W'(1);
      if (step_q == STEPS_W'(DATA_W - 1)) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      step_q   <= '0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      step_q   <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    div_q  <= div_d;
    rem_q  <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule
